// ===== sv/arpc_pkg.sv =====
// Shared types, constants and result codes of the ARP cache and responder.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0] HW_LEN_ETH = 8'd6;
    localparam logic [7:0] PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] OP_REQUEST = 16'h0001;

    localparam logic [31:0] OWN_IP_RESET = 32'h0A00_0002;
    localparam logic [47:0] OWN_MAC_RESET = 48'h0011_2233_4455;

    localparam logic CFG_OWN_IP = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    localparam logic [1:0] RES_DROP = 2'd0;
    localparam logic [1:0] RES_UPDATED = 2'd1;
    localparam logic [1:0] RES_INSERTED = 2'd2;
    localparam logic [1:0] RES_FULL = 2'd3;

    typedef struct packed {
        logic        start;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cache_req;

    typedef struct packed {
        logic       done;
        logic [1:0] result;
    } t_cache_rsp;

endpackage

// ===== sv/arpc_cache.sv =====
// Cache store and sequential lookup/insert walk over all entries.
module arpc_cache
    import arpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cache_req i_req,
    output t_cache_rsp o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    logic                     r_state;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_issue;
    logic                     r_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx;
    logic                     r_rd_used;
    logic [31:0]              r_rd_ip;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_free_idx;
    logic [31:0]              r_key_ip;
    logic [47:0]              r_key_mac;
    logic [CACHE_ENTRIES-1:0] r_used;
    logic [31:0]              r_ip_mem [CACHE_ENTRIES];
    logic [47:0]              r_mac_mem [CACHE_ENTRIES];
    logic                     r_done;
    logic [1:0]               r_result;

    logic             w_hit;
    logic             w_fnd;
    logic [IDX_W-1:0] w_fidx;
    logic             w_ip_we;
    logic             w_mac_we;
    logic [IDX_W-1:0] w_wr_idx;

    assign w_hit = r_cmp_vld && r_rd_used && (r_rd_ip == r_key_ip);
    assign w_fnd = r_free_found || !r_rd_used;
    assign w_fidx = r_free_found ? r_free_idx : r_cmp_idx;
    assign w_mac_we = w_hit || (r_cmp_vld && (r_cmp_idx == LAST_IDX) && w_fnd);
    assign w_ip_we = !w_hit && w_mac_we;
    assign w_wr_idx = w_hit ? r_cmp_idx : w_fidx;

    always_ff @(posedge i_clk) begin
        if (w_ip_we) begin
            r_ip_mem[w_wr_idx] <= r_key_ip;
        end
        if (w_mac_we) begin
            r_mac_mem[w_wr_idx] <= r_key_mac;
        end
        r_rd_ip <= r_ip_mem[r_idx];
        r_rd_used <= r_used[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
            r_issue <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_free_found <= 1'b0;
            r_free_idx <= '0;
            r_used <= '0;
            r_done <= 1'b0;
            r_result <= RES_DROP;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_key_ip <= i_req.ip;
                        r_key_mac <= i_req.mac;
                        r_idx <= '0;
                        r_issue <= 1'b1;
                        r_cmp_vld <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= r_issue;
                    r_cmp_idx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (w_hit) begin
                        r_done <= 1'b1;
                        r_result <= RES_UPDATED;
                        r_issue <= 1'b0;
                        r_cmp_vld <= 1'b0;
                        r_state <= ST_IDLE;
                    end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                        r_done <= 1'b1;
                        r_result <= w_fnd ? RES_INSERTED : RES_FULL;
                        if (w_fnd) begin
                            r_used[w_fidx] <= 1'b1;
                        end
                        r_cmp_vld <= 1'b0;
                        r_state <= ST_IDLE;
                    end else if (r_cmp_vld) begin
                        r_free_found <= w_fnd;
                        r_free_idx <= w_fidx;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.result = r_result;

endmodule

// ===== sv/arp_cache_and_responder_unit.sv =====
// Top level: ARP packet check, cache walk control, reply decision and output register.
//
// Channel   Dir  Handshake              Payload
// s stream  in   i_s_tvalid/o_s_tready  i_s_tdata, 224 bits, one decoded ARP packet
// m stream  out  o_m_tvalid/i_m_tready  o_m_tdata, 136 bits, cache result and reply
// config    in   i_cfg_we               i_cfg_addr, i_cfg_data (own IP, own MAC)
//
// On a well-formed packet the cache walk reads one entry per cycle through a registered
// read port and compares it in the next; the walk stops at the first hit or after the last entry.
// A malformed packet skips the cache walk.
// Reset clears all valid bits of the cache.
// One word is processed at a time; a finished word waits in the output register
// while the next input word is already accepted, and a result that finds the output
// register still full holds the input until that word is taken.
module arp_cache_and_responder_unit
    import arpc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // eth_src_mac, hw_type, proto_type, hw_len, proto_len, op_code,
    // sender_mac, sender_ip, target_ip
    input  logic [223:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // cache_result, reply_valid, reply_eth_dest, reply_target_mac,
    // reply_target_ip, zero padding
    output logic [135:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [47:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]   r_state;
    logic [1:0]   n_state;
    logic [31:0]  r_own_ip;
    logic [47:0]  r_own_mac;
    logic [47:0]  r_eth_src;
    logic [15:0]  r_op;
    logic [47:0]  r_smac;
    logic [31:0]  r_sip;
    logic [31:0]  r_tip;
    logic [1:0]   r_res;
    logic         r_out_valid;
    logic [1:0]   r_out_res;
    logic         r_out_reply;
    logic [47:0]  r_out_dest;
    logic [47:0]  r_out_tmac;
    logic [31:0]  r_out_tip;

    logic         w_accept;
    logic         w_malformed;
    logic         w_load;
    logic         w_reply;
    t_cache_req   w_req;
    t_cache_rsp   w_rsp;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_malformed = (i_s_tdata[63:48] != HW_TYPE_ETH)
                      || (i_s_tdata[79:64] != PROTO_TYPE_IPV4)
                      || (i_s_tdata[87:80] != HW_LEN_ETH)
                      || (i_s_tdata[95:88] != PROTO_LEN_IPV4);
    assign w_load = (r_state == ST_WAIT) && (!r_out_valid || i_m_tready);
    assign w_reply = (r_res != RES_DROP) && (r_tip == r_own_ip) && (r_op == OP_REQUEST);

    assign w_req.start = w_accept && !w_malformed;
    assign w_req.ip = i_s_tdata[191:160];
    assign w_req.mac = i_s_tdata[159:112];

    arpc_cache u_cache (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_malformed ? ST_WAIT : ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_rsp.done) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_own_ip <= OWN_IP_RESET;
            r_own_mac <= OWN_MAC_RESET;
            r_out_valid <= 1'b0;
            r_res <= RES_DROP;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_OWN_IP) begin
                    r_own_ip <= i_cfg_data[31:0];
                end else begin
                    r_own_mac <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_res <= RES_DROP;
            end else if ((r_state == ST_BUSY) && w_rsp.done) begin
                r_res <= w_rsp.result;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_eth_src <= i_s_tdata[47:0];
            r_op <= i_s_tdata[111:96];
            r_smac <= i_s_tdata[159:112];
            r_sip <= i_s_tdata[191:160];
            r_tip <= i_s_tdata[223:192];
        end
        if (w_load) begin
            r_out_res <= r_res;
            r_out_reply <= w_reply;
            r_out_dest <= w_reply ? r_eth_src : 48'd0;
            r_out_tmac <= w_reply ? r_smac : 48'd0;
            r_out_tip <= w_reply ? r_sip : 32'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {5'd0, r_out_tip, r_out_tmac, r_out_dest, r_out_reply, r_out_res};

`ifndef SYNTH
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_BUSY))
        else $error("cache walk finished outside of a busy packet");

    a_load_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_out_valid) |=> r_out_valid)
        else $error("output word was not loaded");

    a_drop_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_res == RES_DROP)) |-> !r_out_reply)
        else $error("reply given for a dropped packet");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> (r_state == ST_BUSY))
        else $error("cache walk started without entering busy");
`endif

endmodule

// ===== sim/arp_cache_and_responder_check.sv =====
// Word layouts and the checker that predicts and compares ARP cache and reply results.
`timescale 1ns / 1ps

package arpc_tb_pkg;

    localparam logic [15:0] OP_REPLY = 16'h0002;

    typedef struct packed {
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] op_code;
        logic [7:0]  proto_len;
        logic [7:0]  hw_len;
        logic [15:0] proto_type;
        logic [15:0] hw_type;
        logic [47:0] eth_src_mac;
    } t_arp_word;

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] reply_target_ip;
        logic [47:0] reply_target_mac;
        logic [47:0] reply_eth_dest;
        logic        reply_valid;
        logic [1:0]  cache_result;
    } t_arp_result;

endpackage

module arp_cache_and_responder_check
    import arpc_pkg::*;
    import arpc_tb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [223:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [47:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    logic        cache_used [CACHE_ENTRIES];
    logic [31:0] cache_ip   [CACHE_ENTRIES];
    logic [47:0] cache_mac  [CACHE_ENTRIES];
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    t_arp_result results_due[$];
    int          fail_count = 0;

    function automatic t_arp_result resolve_packet(input t_arp_word w);
        t_arp_result r;
        int          slot;
        r = '0;
        if (w.hw_type != HW_TYPE_ETH || w.proto_type != PROTO_TYPE_IPV4 ||
            w.hw_len != HW_LEN_ETH || w.proto_len != PROTO_LEN_IPV4) begin
            return r;
        end
        slot = -1;
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (slot < 0 && cache_used[k] && cache_ip[k] == w.sender_ip) begin
                slot = k;
            end
        end
        if (slot >= 0) begin
            cache_mac[slot] = w.sender_mac;
            r.cache_result = RES_UPDATED;
        end else begin
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                if (slot < 0 && !cache_used[k]) begin
                    slot = k;
                end
            end
            if (slot >= 0) begin
                cache_used[slot] = 1'b1;
                cache_ip[slot] = w.sender_ip;
                cache_mac[slot] = w.sender_mac;
                r.cache_result = RES_INSERTED;
            end else begin
                r.cache_result = RES_FULL;
            end
        end
        if (w.target_ip == own_ip && w.op_code == OP_REQUEST) begin
            r.reply_valid = 1'b1;
            r.reply_eth_dest = w.eth_src_mac;
            r.reply_target_mac = w.sender_mac;
            r.reply_target_ip = w.sender_ip;
        end
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [47:0] want,
                                         input logic [47:0] seen);
        if (want !== seen) begin
            $error("%s expected 0x%0h, got 0x%0h", name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_arp_result seen;
        t_arp_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                cache_used[k] = 1'b0;
                cache_ip[k] = '0;
                cache_mac[k] = '0;
            end
            own_ip = OWN_IP_RESET;
            own_mac = OWN_MAC_RESET;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = t_arp_result'(i_m_tdata);
                if (results_due.size() == 0) begin
                    $error("result word 0x%0h with no packet outstanding", i_m_tdata);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    fail_count += field_differs("cache_result", 48'(want.cache_result),
                                                48'(seen.cache_result));
                    fail_count += field_differs("reply_valid", 48'(want.reply_valid),
                                                48'(seen.reply_valid));
                    fail_count += field_differs("reply_eth_dest", want.reply_eth_dest,
                                                seen.reply_eth_dest);
                    fail_count += field_differs("reply_target_mac", want.reply_target_mac,
                                                seen.reply_target_mac);
                    fail_count += field_differs("reply_target_ip", 48'(want.reply_target_ip),
                                                48'(seen.reply_target_ip));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_OWN_IP) begin
                    own_ip = i_cfg_data[31:0];
                end else begin
                    own_mac = i_cfg_data;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                results_due.push_back(resolve_packet(t_arp_word'(i_s_tdata)));
            end
        end
        o_fail_count <= fail_count;
        o_pending <= results_due.size();
    end

endmodule

// ===== sim/tb_arp_cache_and_responder_unit.sv =====
// Testbench top: clock, reset, ARP packet stimulus, register writes and the final verdict.
`timescale 1ns / 1ps

module tb_arp_cache_and_responder_unit;
    import arpc_pkg::*;
    import arpc_tb_pkg::*;

    localparam int PHASES = 4;
    localparam int PHASE_WORDS = 488;
    localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [135:0] o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = CFG_OWN_IP;
    logic [47:0]  i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;
    logic [31:0] own_ip_now = OWN_IP_RESET;
    logic [31:0] cached_ips [CACHE_ENTRIES];

    arp_cache_and_responder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    arp_cache_and_responder_check u_arp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The receiver switches between always ready, half ready and mostly stalled.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(2);
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= ($urandom_range(99) < 50);
            end
            default: begin
                i_m_tready <= ($urandom_range(99) < 20);
            end
        endcase
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic t_arp_word make_packet(input logic [15:0] op, input logic [31:0] sip,
                                              input logic [31:0] tip);
        t_arp_word w;
        w.eth_src_mac = rand48();
        w.hw_type = HW_TYPE_ETH;
        w.proto_type = PROTO_TYPE_IPV4;
        w.hw_len = HW_LEN_ETH;
        w.proto_len = PROTO_LEN_IPV4;
        w.op_code = op;
        w.sender_mac = rand48();
        w.sender_ip = sip;
        w.target_ip = tip;
        return w;
    endfunction

    task automatic send_packet(input t_arp_word w);
        int gap;
        i_s_tdata <= w;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 30);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(7);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_arp_word   w;
        logic [15:0] op;
        logic [31:0] sip;
        logic [31:0] tip;
        int          pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Malformed headers, one bad field at a time.
        w = make_packet(OP_REQUEST, 32'h0, own_ip_now);
        w.hw_type = 16'h0000;
        send_packet(w);
        w = make_packet(OP_REQUEST, 32'h0, own_ip_now);
        w.hw_type = 16'hFFFF;
        send_packet(w);
        w = make_packet(OP_REQUEST, 32'h0, own_ip_now);
        w.proto_type = 16'hFFFF;
        send_packet(w);
        w = make_packet(OP_REQUEST, 32'h0, own_ip_now);
        w.hw_len = 8'hFF;
        send_packet(w);
        w = make_packet(OP_REQUEST, 32'h0, own_ip_now);
        w.proto_len = 8'h00;
        send_packet(w);

        // Insert with reply, then update without reply, at address zero; insert and update without reply at all ones.
        cached_ips[0] = 32'h0000_0000;
        cached_ips[1] = 32'hFFFF_FFFF;
        w = make_packet(OP_REQUEST, cached_ips[0], own_ip_now);
        w.eth_src_mac = '0;
        w.sender_mac = '0;
        send_packet(w);
        w = make_packet(OP_REPLY, cached_ips[0], own_ip_now);
        w.eth_src_mac = '1;
        w.sender_mac = '1;
        send_packet(w);
        send_packet(make_packet(16'hFFFF, cached_ips[1], own_ip_now));
        send_packet(make_packet(16'h0000, cached_ips[1], own_ip_now));

        // Fill the rest of the cache.
        for (int k = 2; k < CACHE_ENTRIES; k++) begin
            cached_ips[k] = {8'(k), 24'($urandom)};
            op = ($urandom_range(1) == 0) ? OP_REQUEST : OP_REPLY;
            tip = ($urandom_range(1) == 0) ? own_ip_now : $urandom;
            send_packet(make_packet(op, cached_ips[k], tip));
        end

        // Cache full: the insert is lost but the reply still goes out.
        send_packet(make_packet(OP_REQUEST, 32'hC0A8_0101, own_ip_now));
        send_packet(make_packet(OP_REQUEST, cached_ips[CACHE_ENTRIES - 1], own_ip_now));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    own_ip_now = $urandom;
                    write_reg(CFG_OWN_MAC, 48'h0);
                end
                1: begin
                    own_ip_now = 32'h0000_0000;
                    write_reg(CFG_OWN_MAC, '1);
                end
                2: begin
                    own_ip_now = 32'hFFFF_FFFF;
                    write_reg(CFG_OWN_MAC, rand48());
                end
                default: begin
                    own_ip_now = $urandom;
                    write_reg(CFG_OWN_MAC, rand48());
                end
            endcase
            write_reg(CFG_OWN_IP, {16'($urandom), own_ip_now});

            for (int n = 0; n < PHASE_WORDS; n++) begin
                sip = ($urandom_range(99) < 70)
                    ? cached_ips[IDX_W'($urandom_range(CACHE_ENTRIES - 1))]
                    : $urandom;
                pick = $urandom_range(99);
                op = (pick < 45) ? OP_REQUEST :
                     (pick < 75) ? OP_REPLY : 16'($urandom);
                pick = $urandom_range(99);
                tip = (pick < 50) ? own_ip_now :
                      (pick < 70) ? own_ip_now ^ (32'h1 << $urandom_range(31)) : $urandom;
                w = make_packet(op, sip, tip);
                if ($urandom_range(99) < 15) begin
                    case ($urandom_range(4))
                        0: begin
                            w.hw_type ^= 16'($urandom_range(1, 65535));
                        end
                        1: begin
                            w.proto_type ^= 16'($urandom_range(1, 65535));
                        end
                        2: begin
                            w.hw_len ^= 8'($urandom_range(1, 255));
                        end
                        3: begin
                            w.proto_len ^= 8'($urandom_range(1, 255));
                        end
                        default: begin
                            w.hw_type = 16'($urandom);
                            w.proto_type = 16'($urandom);
                            w.hw_len = 8'($urandom);
                            w.proto_len = 8'($urandom);
                        end
                    endcase
                end
                send_packet(w);
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("arp_cache_and_responder_unit verification clean");
        end else begin
            $display("arp_cache_and_responder_unit verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("arp_cache_and_responder_unit verification failed");
        $finish;
    end

endmodule
